[rtl/core/mm64_pkg.sv]
// Package for the 64-bit modular multiplier: word types, widths and the
// modular add helper used by the multiply pipeline stages. No dependencies.
package mm64_pkg;

  localparam int unsigned DataW = 64;
  localparam logic [DataW-1:0] ResetModulus = 64'd65537;
  localparam logic [DataW-1:0] MinModulus = 64'd2;

  typedef struct packed {
    logic [DataW-1:0] op_a;
    logic [DataW-1:0] op_b;
  } in_word_t;

  typedef struct packed {
    logic [DataW-1:0] product_mod;
    logic             bad_modulus;
  } out_word_t;

  // (x + y) mod m for x, y below m; the sum is kept one bit wider.
  function automatic logic [DataW-1:0] add_mod(input logic [DataW-1:0] x,
                                               input logic [DataW-1:0] y,
                                               input logic [DataW-1:0] m);
    logic [DataW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[DataW-1:0];
  endfunction

endpackage

[rtl/core/modular_multiply_64_top.sv]
// Top level of the 64-bit modular multiplier: configuration register,
// reduction and multiply pipelines, output register. Depends on mm64_pkg,
// mm64_reduce and mm64_mulmod.
//
//   port group   direction  handshake           word
//   in_*         input      in_valid/in_stall   in_word_t {op_a, op_b}
//   out_*        output     out_valid/out_stall out_word_t {product_mod, bad_modulus}
//   cfg_*        input      cfg_valid/cfg_ready 64-bit modulus
//
// The datapath holds 64 reduction stages, 128 multiply stages (one
// doubling and one conditional add per multiplier bit) and the output register.
// One word is accepted every cycle while the output is not stalled.
// A stall on a full output freezes the whole pipeline; in_stall follows it.
// Synchronous reset empties the pipeline and sets the modulus to 65537.
module modular_multiply_64_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  mm64_pkg::in_word_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output mm64_pkg::out_word_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mm64_pkg::DataW-1:0]  cfg_data
);

  logic [mm64_pkg::DataW-1:0] modulus;
  logic                       en;
  logic                       red_valid;
  logic [mm64_pkg::DataW-1:0] red_a, red_b;
  logic                       prod_valid;
  logic [mm64_pkg::DataW-1:0] prod;
  logic                       bad;

  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;
  assign bad       = modulus < mm64_pkg::MinModulus;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= mm64_pkg::ResetModulus;
    end else if (cfg_valid) begin
      modulus <= cfg_data;
    end
  end

  mm64_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .modulus   (modulus),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .red_valid (red_valid),
    .red_a     (red_a),
    .red_b     (red_b)
  );

  mm64_mulmod u_mulmod (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .modulus    (modulus),
    .red_valid  (red_valid),
    .red_a      (red_a),
    .red_b      (red_b),
    .prod_valid (prod_valid),
    .prod       (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= prod_valid;
    end
  end

  // A modulus below two gives a zero product with the error flag set.
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.product_mod <= bad ? '0 : prod;
      out_data.bad_modulus <= bad;
    end
  end

endmodule

[rtl/core/mm64_reduce.sv]
// Restoring reduction of both factors modulo the modulus, one bit per stage.
// Depends on mm64_pkg.
module mm64_reduce (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [mm64_pkg::DataW-1:0]  modulus,
  input  logic                        in_valid,
  input  mm64_pkg::in_word_t          in_data,
  output logic                        red_valid,
  output logic [mm64_pkg::DataW-1:0]  red_a,
  output logic [mm64_pkg::DataW-1:0]  red_b
);

  localparam int unsigned N = mm64_pkg::DataW;

  logic         v    [N];
  logic [N-1:0] ra   [N];
  logic [N-1:0] rb   [N];
  logic [N-1:0] sa   [N];
  logic [N-1:0] sb   [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic         src_v;
    logic [N-1:0] src_ra, src_rb, src_sa, src_sb;
    logic [N:0]   ta, tb;

    if (k == 0) begin : g_first
      assign src_v  = in_valid;
      assign src_ra = '0;
      assign src_rb = '0;
      assign src_sa = in_data.op_a;
      assign src_sb = in_data.op_b;
    end else begin : g_next
      assign src_v  = v[k-1];
      assign src_ra = ra[k-1];
      assign src_rb = rb[k-1];
      assign src_sa = sa[k-1];
      assign src_sb = sb[k-1];
    end

    // Bring down the next dividend bit, then subtract once if it fits.
    always_comb begin
      ta = {src_ra, src_sa[N-1]};
      tb = {src_rb, src_sb[N-1]};
      if (ta >= {1'b0, modulus}) begin
        ta = ta - {1'b0, modulus};
      end
      if (tb >= {1'b0, modulus}) begin
        tb = tb - {1'b0, modulus};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ra[k] <= ta[N-1:0];
        rb[k] <= tb[N-1:0];
        sa[k] <= {src_sa[N-2:0], 1'b0};
        sb[k] <= {src_sb[N-2:0], 1'b0};
      end
    end
  end

  assign red_valid = v[N-1];
  assign red_a     = ra[N-1];
  assign red_b     = rb[N-1];

endmodule

[rtl/core/mm64_mulmod.sv]
// Double-and-add modular multiplier, MSB first, with the doubling and the
// conditional add in separate register stages. Depends on mm64_pkg.
module mm64_mulmod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [mm64_pkg::DataW-1:0]  modulus,
  input  logic                        red_valid,
  input  logic [mm64_pkg::DataW-1:0]  red_a,
  input  logic [mm64_pkg::DataW-1:0]  red_b,
  output logic                        prod_valid,
  output logic [mm64_pkg::DataW-1:0]  prod
);

  localparam int unsigned N = mm64_pkg::DataW;

  logic         dv   [N];
  logic [N-1:0] dacc [N];
  logic [N-1:0] dx   [N];
  logic [N-1:0] dy   [N];
  logic         av   [N];
  logic [N-1:0] aacc [N];
  logic [N-1:0] ax   [N];
  logic [N-1:0] ay   [N];

  for (genvar k = 0; k < N; k++) begin : g_bit
    logic         src_v;
    logic [N-1:0] src_acc, src_x, src_y;

    if (k == 0) begin : g_first
      assign src_v   = red_valid;
      assign src_acc = '0;
      assign src_x   = red_a;
      assign src_y   = red_b;
    end else begin : g_next
      assign src_v   = av[k-1];
      assign src_acc = aacc[k-1];
      assign src_x   = ax[k-1];
      assign src_y   = ay[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
        av[k] <= 1'b0;
      end else if (en) begin
        dv[k] <= src_v;
        av[k] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dacc[k] <= mm64_pkg::add_mod(src_acc, src_acc, modulus);
        dx[k]   <= src_x;
        dy[k]   <= src_y;
        aacc[k] <= dy[k][N-1] ? mm64_pkg::add_mod(dacc[k], dx[k], modulus) : dacc[k];
        ax[k]   <= dx[k];
        ay[k]   <= {dy[k][N-2:0], 1'b0};
      end
    end
  end

  assign prod_valid = av[N-1];
  assign prod       = aacc[N-1];

endmodule

[rtl/core/mm64_checker.sv]
// Port-level checks for the 64-bit modular multiplier, bound to the top level.
// Depends on mm64_pkg.
module mm64_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input mm64_pkg::out_word_t         out_data
);

  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

  a_bad_gives_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.bad_modulus) |-> (out_data.product_mod == '0))
    else $error("error word carries a nonzero product");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled output word changed");

endmodule

bind modular_multiply_64_top mm64_checker u_mm64_checker (.*);
